### design/pfbf_pkg.sv
// Shared types and constants for the planar framebuffer blit and fill block.
`timescale 1ns / 1ps
package pfbf_pkg;
  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_PIXEL = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OFF      = 2'd1;
  localparam logic [1:0] ST_NO_BLIT  = 2'd2;

  typedef struct packed {
    op_t         op;
    logic [9:0]  pos_x;
    logic [8:0]  pos_y;
    logic [9:0]  rect_width;
    logic [8:0]  rect_height;
    logic [3:0]  color;
    logic [15:0] byte_addr;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_init;
    logic clear_step;
    logic load_item;
    logic fill_start;
    logic fill_step;
    logic exec;
    logic read_issue;
    logic read_cap;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic fill_needed;
    logic fill_last;
    logic is_read;
  } stat_t;

  function automatic logic [31:0] spread4(input logic [7:0] b);
    return {b, b, b, b};
  endfunction
endpackage

### design/planar_framebuffer_blit_fill_top.sv
// Top level of the planar framebuffer fill and blit block.
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   op, pos, size, color, byte_addr
//  m_axis   out  m_axis_tvalid/tready   status, four plane bytes
// A transaction passes the decode step, then the fill walk over the rectangle's
// bytes row by row for a fill or the frame memory read for a read, and then the
// done step that loads the result register.
// After reset the memory is cleared one entry a cycle, all Pitch*SCREEN_HEIGHT
// entries, before the first transaction is accepted.
// A result waits in the output register; the next item is held off until taken.
`timescale 1ns / 1ps
module planar_framebuffer_blit_fill_top #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], pos_x[11:2], pos_y[20:12], rect_width[30:21], rect_height[39:31],
  // color[43:40], byte_addr[59:44]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], plane0[9:2], plane1[17:10], plane2[25:18], plane3[33:26]
  output logic [39:0] m_axis_tdata
);
  import pfbf_pkg::*;

  item_t   item;
  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    res_load;

  assign item.op          = op_t'(s_axis_tdata[1:0]);
  assign item.pos_x       = s_axis_tdata[11:2];
  assign item.pos_y       = s_axis_tdata[20:12];
  assign item.rect_width  = s_axis_tdata[30:21];
  assign item.rect_height = s_axis_tdata[39:31];
  assign item.color       = s_axis_tdata[43:40];
  assign item.byte_addr   = s_axis_tdata[59:44];

  pfbf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .res_load(res_load), .res_busy(m_axis_tvalid), .stat(stat), .cmd(cmd)
  );

  pfbf_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .item(item), .cmd(cmd), .stat(stat), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (res_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (res_load) m_axis_tdata <= {6'd0, res.word, res.status};
  end
endmodule

### design/pfbf_ctrl.sv
// Controller state machine for the planar framebuffer block.
`timescale 1ns / 1ps
module pfbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            res_load,
  input  logic            res_busy,
  input  pfbf_pkg::stat_t stat,
  output pfbf_pkg::cmd_t  cmd
);
  import pfbf_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_IDLE  = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.clear_init = 1'b1;
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !res_busy;
        if (in_valid && !res_busy) begin
          cmd.load_item = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_read) begin
          cmd.read_issue = 1'b1;
          state_next = S_READ;
        end else if (stat.fill_needed) begin
          cmd.fill_start = 1'b1;
          state_next = S_FILL;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) state_next = S_DONE;
      end
      S_READ: begin
        cmd.read_cap = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        res_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end
endmodule

### design/pfbf_dp.sv
// Datapath with frame memory, fill walker and blit packer.
`timescale 1ns / 1ps
module pfbf_dp #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic              clk,
  input  logic              rst,
  input  pfbf_pkg::item_t   item,
  input  pfbf_pkg::cmd_t    cmd,
  output pfbf_pkg::stat_t   stat,
  output pfbf_pkg::result_t res
);
  import pfbf_pkg::*;

  localparam int Pitch = (SCREEN_WIDTH + 7) / 8;
  localparam int Bytes = Pitch * SCREEN_HEIGHT;
  localparam int AW = $clog2(Bytes);
  localparam int BW = $clog2(Pitch);

  logic [31:0] mem [Bytes];

  item_t it;
  logic [1:0] status;
  logic [31:0] word;

  logic [AW:0]  clr_addr;
  // Fill walker.
  logic [AW:0]  row_base;
  logic [BW:0]  fb, lb, rb;
  logic [8:0]   rows_left;
  logic [7:0]   lmask, rmask;
  logic [31:0]  fill_word;
  logic [7:0]   fmask;

  // Blit state.
  logic [9:0]  bx, bw, bcol;
  logic [8:0]  by, bh, brow;
  logic [31:0] pack_bits;
  logic [7:0]  pack_mask;
  logic        active;

  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;
  logic [31:0] rd_data;

  // Read-modify-write is done by a read in one step and merge on the next.
  logic        rmw_pend;
  logic [AW-1:0] rmw_addr;
  logic [31:0] rmw_bits, rmw_m;

  logic [10:0] ex, rx;
  logic [9:0]  ey;
  logic        empty, off;
  logic [10:0] pxx;
  logic [9:0]  pyy;
  logic [2:0]  bit_i;
  logic        flush, col_end;
  logic        pix_wr;
  logic [31:0] nb;
  logic [7:0]  nm;
  logic [AW+10:0] paddr;
  logic [AW+10:0] fill_rb;

  assign ex = {1'b0, it.pos_x} + {1'b0, it.rect_width};
  assign ey = {1'b0, it.pos_y} + {1'b0, it.rect_height};
  assign rx = ex - 11'd1;
  assign empty = (it.rect_width == '0) || (it.rect_height == '0);
  assign off = (32'(ex) > SCREEN_WIDTH) || (32'(ey) > SCREEN_HEIGHT);

  assign stat.is_read = (it.op == OP_READ);
  assign stat.fill_needed = (it.op == OP_FILL) && !empty && !off;
  assign stat.fill_last = (rows_left == 9'd1) && (fb == rb);
  assign stat.clear_done = (clr_addr == (AW+1)'(Bytes - 1));

  assign pxx = {1'b0, bx} + {1'b0, bcol};
  assign pyy = {1'b0, by} + {1'b0, brow};
  assign bit_i = 3'd7 - pxx[2:0];
  assign col_end = ({1'b0, bcol} + 11'd1) >= {1'b0, bw};
  assign flush = (bit_i == 3'd0) || col_end;
  assign paddr = (AW+11)'(pyy) * (AW+11)'(Pitch) + (AW+11)'(pxx[10:3]);
  assign fill_rb = (AW+11)'(row_base) + (AW+11)'(fb);
  assign fmask = ((fb == lb) ? lmask : 8'hFF) & ((fb == rb) ? rmask : 8'hFF);
  assign pix_wr = cmd.exec && it.op == OP_PIXEL && active && flush &&
                  paddr < (AW+11)'(Bytes);

  always_comb begin
    nb = pack_bits;
    for (int n = 0; n < 4; n++) nb[8*n + bit_i] = it.color[n];
    nm = pack_mask | (8'd1 << bit_i);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.clear_step || cmd.clear_init) begin
      wr_en = 1'b1;
      wr_addr = cmd.clear_init ? '0 : clr_addr[AW-1:0];
    end else if (rmw_pend) begin
      wr_en = 1'b1;
      wr_addr = rmw_addr;
      wr_data = (rd_data & ~rmw_m) | (rmw_bits & rmw_m);
    end
  end

  // The fill issues a read each step; merge follows next cycle via rmw_pend.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.fill_step) begin
      rd_data  <= mem[fill_rb[AW-1:0]];
      rmw_addr <= fill_rb[AW-1:0];
      rmw_bits <= fill_word;
      rmw_m    <= spread4(fmask);
    end else if (pix_wr) begin
      rd_data  <= mem[paddr[AW-1:0]];
      rmw_addr <= paddr[AW-1:0];
      rmw_bits <= nb;
      rmw_m    <= spread4(nm);
    end else if (cmd.read_issue) begin
      rd_data <= mem[it.byte_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rmw_pend <= 1'b0;
    else rmw_pend <= cmd.fill_step || pix_wr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) it <= item;
    if (cmd.clear_init) clr_addr <= '0;
    else if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
    if (cmd.fill_start) begin
      row_base <= (AW+1)'((AW+11)'(it.pos_y) * (AW+11)'(Pitch));
      lb <= (BW+1)'(it.pos_x[9:3]);
      fb <= (BW+1)'(it.pos_x[9:3]);
      rb <= (BW+1)'(rx[10:3]);
      rows_left <= it.rect_height;
      lmask <= 8'hFF >> it.pos_x[2:0];
      rmask <= 8'hFF << (3'd7 - rx[2:0]);
      for (int n = 0; n < 4; n++) fill_word[8*n +: 8] <= {8{it.color[n]}};
    end else if (cmd.fill_step) begin
      if (fb == rb) begin
        fb <= lb;
        row_base <= row_base + (AW+1)'(Pitch);
        rows_left <= rows_left - 9'd1;
      end else begin
        fb <= fb + 1'b1;
      end
    end
    if (cmd.load_item) status <= ST_OK;
    if (cmd.exec || cmd.fill_start) begin
      if ((it.op == OP_FILL || it.op == OP_BEGIN) && !empty && off) status <= ST_OFF;
      if (it.op == OP_PIXEL && !active) status <= ST_NO_BLIT;
    end
    if (cmd.load_item) word <= '0;
    if (cmd.read_cap && 32'(it.byte_addr) < Bytes) word <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      bx <= '0; by <= '0; bw <= '0; bh <= '0;
      bcol <= '0; brow <= '0;
      pack_bits <= '0; pack_mask <= '0;
    end else if (cmd.exec && it.op == OP_BEGIN) begin
      active <= !empty && !off;
      pack_bits <= '0; pack_mask <= '0;
      bcol <= '0; brow <= '0;
      if (!empty && !off) begin
        bx <= it.pos_x; by <= it.pos_y; bw <= it.rect_width; bh <= it.rect_height;
      end
    end else if (cmd.exec && it.op == OP_PIXEL && active) begin
      pack_bits <= flush ? '0 : nb;
      pack_mask <= flush ? '0 : nm;
      if (col_end) begin
        bcol <= '0;
        if (({1'b0, brow} + 10'd1) >= {1'b0, bh}) begin
          brow <= '0;
          active <= 1'b0;
        end else begin
          brow <= brow + 9'd1;
        end
      end else begin
        bcol <= bcol + 10'd1;
      end
    end
  end

  assign res.status = status;
  assign res.word = word;
endmodule
